// File: rtl/ltp_pkg.sv
// shared types and constants for the lottery task picker
package ltp_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam logic [15:0] MaxTicketsRst = 16'd140;

  typedef enum logic [2:0] {
    ModeEnqueue = 3'd0,
    ModeDequeue = 3'd1,
    ModePick    = 3'd2,
    ModeReprio  = 3'd3,
    ModePutBack = 3'd4
  } mode_e;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StNoPick   = 3'd3;
  localparam logic [2:0] StPresent  = 3'd4;

  // saturating ticket computation
  function automatic logic [15:0] tickets_for(input logic [15:0] base, input logic [7:0] prio);
    logic [15:0] p;
    p = {8'd0, prio};
    tickets_for = (p >= base) ? 16'd0 : (base - p);
  endfunction

endpackage

// File: rtl/ltp_divider.sv
// restoring divider, one quotient bit per cycle, remainder only
module ltp_divider
  import ltp_pkg::*;
#(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [DenW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DenW:0]   shifted;

  assign shifted = {rem_q[DenW-1:0], num_q[NumW-1]};
  assign rem_o   = rem_q[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      if (shifted >= {1'b0, den_q}) rem_q <= shifted - {1'b0, den_q};
      else rem_q <= shifted;
    end
  end
endmodule

// File: rtl/ltp_table_mem.sv
// task table memory: id and tickets, one write and one registered read port
module ltp_table_mem
  import ltp_pkg::*;
#(
  parameter int unsigned Depth = TableDepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [31:0]              wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [31:0]              rdata_o
);
  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: rtl/lottery_task_picker.sv
// lottery task picker top level: sequencer over the task table memory
//
//  channel   dir  payload                                         accept
//  s_axis_*  in   tdata: mode, task_id, priority_req,             tvalid & tready
//                 task_is_running, random_word
//  m_axis_*  out  tdata: status, pick_valid, picked_task,         tvalid & tready
//                 running_count
//  cfg_*     in   ticket base                                     cfg_we_i
//
// table is kept in a single-port-read memory, entry 0 newest
// enqueue shifts the table up one entry at a time, then writes the new entry at 0;
// dequeue scans for the id, then shifts the later entries down; reprioritize and
// lookups scan the table entry by entry; pick sums the tickets over the table,
// divides the random word by the total and walks the table to the selected entry
// one item is worked at a time; s_axis_tready is low while busy or result held
// reset clears the entry count and restores the ticket base; table contents need no clearing
module lottery_task_picker
  import ltp_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // mode[2:0] task_id[18:3] priority_req[26:19]
                                      // task_is_running[27] random_word[59:28]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status[2:0] pick_valid[3] picked_task[19:4]
                                      // running_count[26:20]
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned SumW  = 16 + CntW;

  typedef enum logic [3:0] {
    SIdle, SScanRd, SScan, SShUpRd, SShUpWr, SShDnRd, SShDnWr,
    SDiv, SWalkRd, SWalk, SPut, SDone
  } state_e;

  state_e           state_q;
  logic [15:0]      ticket_base_q;
  logic [CntW-1:0]  count_q;
  logic [2:0]       mode_q;
  logic [15:0]      id_q;
  logic [7:0]       prio_q;
  logic [31:0]      rnd_q;
  logic [AddrW-1:0] idx_q;
  logic [SumW-1:0]  sum_q;
  logic [SumW-1:0]  target_q;
  logic             hit_q;
  logic [2:0]       status_q;
  logic             pvalid_q;
  logic [15:0]      picked_q;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;
  logic             div_start, div_done;
  logic [31:0]      div_rem;
  logic [15:0]      r_id, r_tk;
  logic             last;

  assign r_id = rdata[15:0];
  assign r_tk = rdata[31:16];
  assign last = ({1'b0, idx_q} + 1'b1) == (AddrW + 1)'(count_q);

  ltp_table_mem #(.Depth(TableDepth)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // divisor is the full total, including the entry read in the last scan cycle
  ltp_divider #(.NumW(32), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(rnd_q),
    .den_i(32'(sum_q + SumW'(r_tk))), .done_o(div_done), .rem_o(div_rem)
  );

  // memory port control and divider start
  always_comb begin
    we = 1'b0;
    waddr = idx_q;
    wdata = rdata;
    raddr = idx_q;
    div_start = 1'b0;
    case (state_q)
      SShUpWr: begin
        we = 1'b1;
        waddr = idx_q + 1'b1;
      end
      SShDnWr: begin
        we = 1'b1;
        waddr = idx_q - 1'b1;
      end
      SPut: begin
        we = 1'b1;
        waddr = '0;
        wdata = {tickets_for(ticket_base_q, prio_q), id_q};
      end
      SScan: begin
        if (mode_e'(mode_q) == ModeReprio && r_id == id_q) begin
          we = 1'b1;
          wdata = {tickets_for(ticket_base_q, prio_q), id_q};
        end
      end
      SDiv: div_start = 1'b0;
      default: ;
    endcase
    if (state_q == SScan && mode_e'(mode_q) == ModePick && last) div_start = 1'b1;
  end

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = (state_q == SDone);
  assign m_axis_tdata  = {5'd0, 7'(count_q), picked_q, pvalid_q, status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticket_base_q <= MaxTicketsRst;
      state_q <= SIdle;
      count_q <= '0;
    end else begin
      if (cfg_we_i) ticket_base_q <= cfg_wdata_i;
      case (state_q)
        SIdle: if (s_axis_tvalid) begin
          mode_q <= s_axis_tdata[2:0];
          id_q   <= s_axis_tdata[18:3];
          prio_q <= s_axis_tdata[26:19];
          rnd_q  <= s_axis_tdata[59:28];
          status_q <= StOk;
          pvalid_q <= 1'b0;
          picked_q <= '0;
          sum_q <= '0;
          hit_q <= 1'b0;
          idx_q <= '0;
          case (mode_e'(s_axis_tdata[2:0]))
            ModeEnqueue: begin
              if (count_q == CntW'(TableDepth)) begin
                status_q <= StFull;
                state_q <= SDone;
              end else if (count_q == '0) state_q <= SPut;
              else begin
                idx_q <= AddrW'(count_q - 1'b1);
                state_q <= SShUpRd;
              end
            end
            ModeDequeue, ModeReprio: begin
              if (count_q == '0) begin
                status_q <= StNotFound;
                state_q <= SDone;
              end else state_q <= SScanRd;
            end
            ModePick: begin
              if (count_q == '0) begin
                status_q <= StNoPick;
                state_q <= SDone;
              end else state_q <= SScanRd;
            end
            ModePutBack: begin
              if (!s_axis_tdata[27]) state_q <= SDone;
              else if (count_q == '0) state_q <= SPut;
              else state_q <= SScanRd;
            end
            default: state_q <= SDone;
          endcase
        end
        SScanRd: state_q <= SScan;
        SScan: begin
          // rdata holds entry idx_q
          case (mode_e'(mode_q))
            ModeDequeue: begin
              if (r_id == id_q) begin
                hit_q <= 1'b1;
                if (last) begin
                  count_q <= count_q - 1'b1;
                  state_q <= SDone;
                end else begin
                  idx_q <= idx_q + 1'b1;
                  state_q <= SShDnRd;
                end
              end else if (last) begin
                status_q <= StNotFound;
                state_q <= SDone;
              end else begin
                idx_q <= idx_q + 1'b1;
                state_q <= SScanRd;
              end
            end
            ModeReprio: begin
              if (r_id == id_q) hit_q <= 1'b1;
              if (last) begin
                if (!(hit_q || r_id == id_q)) status_q <= StNotFound;
                state_q <= SDone;
              end else begin
                idx_q <= idx_q + 1'b1;
                state_q <= SScanRd;
              end
            end
            ModePick: begin
              sum_q <= sum_q + SumW'(r_tk);
              if (last) begin
                if ((sum_q + SumW'(r_tk)) == '0) begin
                  status_q <= StNoPick;
                  state_q <= SDone;
                end else state_q <= SDiv;
              end else begin
                idx_q <= idx_q + 1'b1;
                state_q <= SScanRd;
              end
            end
            ModePutBack: begin
              if (r_id == id_q) begin
                status_q <= StPresent;
                state_q <= SDone;
              end else if (!last) begin
                idx_q <= idx_q + 1'b1;
                state_q <= SScanRd;
              end else if (count_q == CntW'(TableDepth)) begin
                status_q <= StFull;
                state_q <= SDone;
              end else begin
                idx_q <= AddrW'(count_q - 1'b1);
                state_q <= SShUpRd;
              end
            end
            default: state_q <= SDone;
          endcase
        end
        SDiv: if (div_done) begin
          target_q <= SumW'(div_rem) + 1'b1;
          sum_q <= '0;
          idx_q <= '0;
          state_q <= SWalkRd;
        end
        SWalkRd: state_q <= SWalk;
        SWalk: begin
          if (sum_q + SumW'(r_tk) >= target_q) begin
            pvalid_q <= 1'b1;
            picked_q <= r_id;
            state_q <= SDone;
          end else if (last) begin
            status_q <= StNoPick;
            state_q <= SDone;
          end else begin
            sum_q <= sum_q + SumW'(r_tk);
            idx_q <= idx_q + 1'b1;
            state_q <= SWalkRd;
          end
        end
        SShUpRd: state_q <= SShUpWr;
        SShUpWr: begin
          if (idx_q == '0) state_q <= SPut;
          else begin
            idx_q <= idx_q - 1'b1;
            state_q <= SShUpRd;
          end
        end
        SPut: begin
          count_q <= count_q + 1'b1;
          state_q <= SDone;
        end
        SShDnRd: state_q <= SShDnWr;
        SShDnWr: begin
          if (last) begin
            count_q <= count_q - 1'b1;
            state_q <= SDone;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= SShDnRd;
          end
        end
        SDone: if (m_axis_tready) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// File: rtl/ltp_checker.sv
// port-level checks for the lottery task picker
module ltp_checker
  import ltp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  // one item at a time: no input taken while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  // a result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // a pick result carries a valid id only with ok status
  a_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == StOk)
    else $error("pick with bad status");
  // the count shown with a result never exceeds the default table depth
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[26:20] <= 7'(TableDepthDef))
    else $error("count overflow");
endmodule

bind lottery_task_picker ltp_checker u_ltp_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// File: dv/testbench.sv
// self-checking testbench for the lottery task picker: directed and random items
`timescale 1ns / 100ps

module testbench;
  import ltp_pkg::*;

  localparam int unsigned Depth = TableDepthDef;
  localparam int unsigned IdleLimit = 20000;

  // lowest field last so that the layout matches the result beat
  typedef struct packed {
    logic [6:0]  running_count;
    logic [15:0] picked_task;
    logic        pick_valid;
    logic [2:0]  status;
  } sched_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // mode, task_id, priority_req, task_is_running, random_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // status, pick_valid, picked_task, running_count
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  // shadow copy of the task table, entry 0 newest
  logic [15:0] shadow_task [Depth];
  logic [15:0] shadow_tix [Depth];
  int unsigned shadow_count;
  logic [15:0] shadow_base;

  sched_result_t expected_results[$];
  int unsigned   fail_count;
  int unsigned   idle_cycles;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;

  lottery_task_picker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] ticket_count(logic [7:0] prio);
    if ({8'd0, prio} >= shadow_base) return 16'd0;
    return shadow_base - {8'd0, prio};
  endfunction

  function automatic int find_task(logic [15:0] id);
    for (int i = 0; i < shadow_count; i++) if (shadow_task[i] == id) return i;
    return -1;
  endfunction

  // push a new newest entry, returns the status
  function automatic logic [2:0] insert_newest(logic [15:0] id, logic [7:0] prio);
    if (shadow_count >= Depth) return StFull;
    for (int i = shadow_count; i > 0; i--) begin
      shadow_task[i] = shadow_task[i-1];
      shadow_tix[i] = shadow_tix[i-1];
    end
    shadow_task[0] = id;
    shadow_tix[0] = ticket_count(prio);
    shadow_count++;
    return StOk;
  endfunction

  // predicts the result of one item and updates the shadow table
  function automatic sched_result_t predict_schedule(logic [2:0] mode, logic [15:0] id,
                                                    logic [7:0] prio, logic running,
                                                    logic [31:0] rnd);
    sched_result_t r;
    int pos;
    longint unsigned total, sum, target;
    r = '0;
    case (mode)
      ModeEnqueue: r.status = insert_newest(id, prio);
      ModeDequeue: begin
        pos = find_task(id);
        if (pos < 0) r.status = StNotFound;
        else begin
          for (int i = pos; i < shadow_count - 1; i++) begin
            shadow_task[i] = shadow_task[i+1];
            shadow_tix[i] = shadow_tix[i+1];
          end
          shadow_count--;
        end
      end
      ModePick: begin
        total = 0;
        sum = 0;
        for (int i = 0; i < shadow_count; i++) total += shadow_tix[i];
        if (total == 0) r.status = StNoPick;
        else begin
          target = (longint'(rnd) % total) + 1;
          for (int i = 0; i < shadow_count; i++) begin
            sum += shadow_tix[i];
            if (sum >= target) begin
              r.pick_valid = 1'b1;
              r.picked_task = shadow_task[i];
              break;
            end
          end
          if (!r.pick_valid) r.status = StNoPick;
        end
      end
      ModeReprio: begin
        r.status = StNotFound;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_task[i] == id) begin
            shadow_tix[i] = ticket_count(prio);
            r.status = StOk;
          end
        end
      end
      ModePutBack: begin
        if (running) begin
          if (find_task(id) >= 0) r.status = StPresent;
          else r.status = insert_newest(id, prio);
        end
      end
      default: ;
    endcase
    r.running_count = shadow_count[6:0];
    return r;
  endfunction

  // sends one beat, predicting its result at acceptance; valid drops only when idling
  task automatic send_item(logic [2:0] mode, logic [15:0] id, logic [7:0] prio,
                           logic running, logic [31:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, rnd, running, prio, id, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(predict_schedule(mode, id, prio, running, rnd));
  endtask

  // waits for all results, then pauses (before a register write and at the end of the run)
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_ticket_base(logic [15:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_base = value;
  endtask

  // small id pool so that hits are common
  function automatic logic [15:0] pick_id();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(40)) ^ (($urandom_range(3) == 0) ? 16'hffc0 : 16'h0);
  endfunction

  task automatic random_item();
    int unsigned sel;
    logic [2:0] mode;
    sel = $urandom_range(99);
    if (sel < 28) mode = ModeEnqueue;
    else if (sel < 50) mode = ModeDequeue;
    else if (sel < 70) mode = ModePick;
    else if (sel < 82) mode = ModeReprio;
    else if (sel < 97) mode = ModePutBack;
    else mode = 3'($urandom_range(7, 5));
    send_item(mode, pick_id(), 8'($urandom_range(255)), 1'($urandom), $urandom);
  endtask

  // every mode, extremes and corner cases on an almost empty table
  task automatic test_directed();
    send_item(ModePick, 16'h0, 8'd0, 1'b0, 32'h0);           // pick from empty table
    send_item(ModeDequeue, 16'hffff, 8'd0, 1'b0, 32'h0);     // dequeue with no match
    send_item(ModeReprio, 16'h1, 8'd5, 1'b0, 32'h0);         // reprioritize with no match
    send_item(ModeEnqueue, 16'hffff, 8'd0, 1'b0, 32'hffffffff);
    send_item(ModeEnqueue, 16'h0, 8'd255, 1'b1, 32'h0);      // priority above base
    send_item(ModePick, 16'h0, 8'd0, 1'b0, 32'hffffffff);
    send_item(ModePutBack, 16'h0, 8'd1, 1'b1, 32'h0);        // already present
    send_item(ModePutBack, 16'h1234, 8'd1, 1'b0, 32'h0);     // not running, ignored
    send_item(ModePutBack, 16'h1234, 8'd139, 1'b1, 32'h0);
    send_item(ModeEnqueue, 16'hffff, 8'd10, 1'b0, 32'h0);    // duplicate id
    send_item(ModeReprio, 16'hffff, 8'd140, 1'b0, 32'h0);    // both copies to zero
    send_item(ModePick, 16'h0, 8'd0, 1'b0, 32'h5555aaaa);
    send_item(ModeReprio, 16'h1234, 8'd140, 1'b0, 32'h0);
    send_item(ModeReprio, 16'h0, 8'd140, 1'b0, 32'h0);        // zero total
    send_item(ModePick, 16'h0, 8'd0, 1'b0, 32'h12345678);
    send_item(3'd5, 16'h0, 8'd0, 1'b1, 32'h0);
    send_item(3'd6, 16'h0, 8'd0, 1'b0, 32'h0);
    send_item(3'd7, 16'hffff, 8'hff, 1'b1, 32'hffffffff);
    send_item(ModeDequeue, 16'hffff, 8'd0, 1'b0, 32'h0);
    send_item(ModeDequeue, 16'h1234, 8'd0, 1'b0, 32'h0);
  endtask

  // fill to full, overflow by enqueue and put_back, then empty again
  task automatic test_full_table();
    while (shadow_count < Depth)
      send_item(ModeEnqueue, 16'(shadow_count + 100), 8'($urandom_range(139)), 1'b0, $urandom);
    send_item(ModeEnqueue, 16'h7777, 8'd0, 1'b0, 32'h0);
    send_item(ModePutBack, 16'h7777, 8'd0, 1'b1, 32'h0);
    send_item(ModePick, 16'h0, 8'd0, 1'b0, 32'hffffffff);
    while (shadow_count > 0)
      send_item(ModeDequeue, shadow_task[$urandom_range(shadow_count - 1)], 8'd0, 1'b0, 32'h0);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) random_item();
  endtask

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    sched_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = sched_result_t'(m_axis_tdata[26:0]);
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.pick_valid !== want.pick_valid) begin
          $error("pick_valid expected %0d actual %0d", want.pick_valid, got.pick_valid);
          fail_count++;
        end
        if (got.picked_task !== want.picked_task) begin
          $error("picked_task expected %0d actual %0d", want.picked_task, got.picked_task);
          fail_count++;
        end
        if (got.running_count !== want.running_count) begin
          $error("running_count expected %0d actual %0d", want.running_count,
                 got.running_count);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** lottery_task_picker: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    m_axis_tready = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_count = 0;
    shadow_base = MaxTicketsRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_random(230);
    send_idle_pct = 61;
    write_ticket_base(16'hffff);
    test_random(230);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    write_ticket_base(16'd0);                 // every newly computed ticket count zero
    test_random(60);
    write_ticket_base(16'd1);
    test_random(120);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    write_ticket_base(16'd140);
    test_random(230);

    drain_results();
    if (fail_count == 0) $display("** lottery_task_picker: PASSED **");
    else $display("** lottery_task_picker: FAILED **");
    $finish;
  end

endmodule

// File: lottery_task_picker.f
rtl/ltp_pkg.sv
rtl/ltp_divider.sv
rtl/ltp_table_mem.sv
rtl/lottery_task_picker.sv
rtl/ltp_checker.sv
dv/testbench.sv
